[hdl/lmcd_pkg.sv]
// Shared types and constants for the LED matrix chain driver.
// No dependencies; every other file of the block imports this package.
package lmcd_pkg;

  // Controllers on the chain and rows per controller.
  localparam int DEVICES         = 4;
  localparam int ROWS_PER_DEVICE = 8;
  localparam int SLOT_W          = 16;
  localparam int FRAME_W         = 64;
  localparam int STORE_DEPTH     = 32;
  localparam int STORE_IDX_W     = $clog2(STORE_DEPTH);

  // Command codes.
  typedef enum logic [2:0] {
    OP_RAW     = 3'd0,
    OP_SET_LED = 3'd1,
    OP_SET_ROW = 3'd2,
    OP_SET_COL = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Latched command request.
  typedef struct packed {
    op_t        op;
    logic [1:0] device;
    logic [2:0] row;
    logic [2:0] column;
    logic [7:0] value;
    logic       led_on;
    logic [3:0] reg_addr;
  } cmd_t;

  // Result of one pass through the row unit.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic [7:0] reg_byte;
    logic [7:0] data_byte;
  } upd_t;

endpackage

[hdl/lmcd_store.sv]
// Shadow register file: eight row bytes for each controller, cleared at reset.
// Depends on lmcd_pkg.
module lmcd_store
  import lmcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [STORE_IDX_W-1:0] idx,
  input  logic                   wr_en,
  input  logic [7:0]             wr_data,
  output logic [7:0]             rd_data
);

  logic [7:0] rows_r [STORE_DEPTH];

  // Read and write share one address; the write lands at the end of the cycle.
  assign rd_data = rows_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        rows_r[i] <= '0;
      end
    end else if (wr_en) begin
      rows_r[idx] <= wr_data;
    end
  end

endmodule

[hdl/lmcd_row_unit.sv]
// Shared row update unit: computes the new row byte and the frame slot bytes
// for one step of a command. Depends on lmcd_pkg.
module lmcd_row_unit
  import lmcd_pkg::*;
(
  input  cmd_t       cmd,
  input  logic [2:0] row,
  input  logic [7:0] cur,
  output upd_t       upd
);

  logic [7:0] mask;
  logic       bit_on;
  logic [7:0] led_byte;

  // Column 0 is the leftmost (most significant) bit of a row byte.
  assign mask     = 8'h80 >> cmd.column;
  assign bit_on   = (cmd.op == OP_SET_COL) ? cmd.value[3'd7 - row] : cmd.led_on;
  assign led_byte = bit_on ? (cur | mask) : (cur & ~mask);

  // Register byte is the row number plus one for all store commands.
  always_comb begin
    upd.wr_en     = 1'b1;
    upd.wr_data   = led_byte;
    upd.reg_byte  = {5'd0, row} + 8'd1;
    upd.data_byte = led_byte;
    unique case (cmd.op) inside
      OP_RAW: begin
        upd.wr_en     = 1'b0;
        upd.wr_data   = cur;
        upd.reg_byte  = {4'd0, cmd.reg_addr};
        upd.data_byte = cmd.value;
      end
      OP_SET_ROW: begin
        upd.wr_data   = cmd.value;
        upd.data_byte = cmd.value;
      end
      OP_CLEAR: begin
        upd.wr_data   = '0;
        upd.data_byte = '0;
      end
      OP_SET_LED, OP_SET_COL: begin
        upd.wr_data   = led_byte;
        upd.data_byte = led_byte;
      end
      default: begin
        upd.wr_en = 1'b0;
      end
    endcase
  end

endmodule

[hdl/led_matrix_chain_driver.sv]
// Top level of the LED matrix chain driver: command sequencer and frame output.
// Depends on lmcd_pkg, lmcd_store and lmcd_row_unit.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+------------------------------
//   command  | start, busy, in_*           | taken when start & !busy
//   frame    | out_valid, out_*            | valid with each frame, no backpressure
//
// A command is latched when taken, then the row unit runs one step per cycle:
// one step for raw, set led and set row, eight steps for set column and clear.
// Each step's frame appears in the cycle after its step. busy is high while steps run,
// so the next command can be taken only after the last step of the current one.
// Commands with an unused opcode or a device beyond the chain are taken and dropped
// without frames. The frame receiver cannot stall. Reset is synchronous, active low,
// and clears the shadow store.
module led_matrix_chain_driver
  import lmcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_device,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_column,
  input  logic [7:0]  in_value,
  input  logic        in_led_on,
  input  logic [3:0]  in_register_address,
  output logic        out_valid,
  output logic [63:0] out_frame,
  output logic        out_last_frame
);

  state_t     state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic       last_r, last_nxt;

  logic       accept;
  logic       cmd_ok;
  logic       multi;
  logic       last_step;
  logic [2:0] cur_row;
  logic [7:0] rd_data;
  upd_t       upd;
  logic       run;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign run    = (state_r == ST_RUN);

  // Drop commands with unused opcodes or a device past the end of the chain.
  assign cmd_ok = ({1'b0, in_device} < 3'(DEVICES)) && (in_opcode <= OP_CLEAR);

  // Column and clear commands sweep all rows; the rest touch one row.
  assign multi     = (cmd_r.op == OP_SET_COL) || (cmd_r.op == OP_CLEAR);
  assign cur_row   = multi ? step_r : cmd_r.row;
  assign last_step = !multi || (step_r == 3'd7);

  lmcd_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     ({cmd_r.device, cur_row}),
    .wr_en   (run && upd.wr_en),
    .wr_data (upd.wr_data),
    .rd_data (rd_data)
  );

  lmcd_row_unit u_row (
    .cmd (cmd_r),
    .row (cur_row),
    .cur (rd_data),
    .upd (upd)
  );

  // Sequencer: latch a request, then step through rows.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = '{op: op_t'(in_opcode), device: in_device, row: in_row,
                      column: in_column, value: in_value, led_on: in_led_on,
                      reg_addr: in_register_address};
          step_nxt = '0;
          if (cmd_ok) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 3'd1;
        if (last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Frame assembly: only the target controller's slot is nonzero.
  always_comb begin
    out_valid_nxt = run;
    last_nxt      = last_step;
    frame_nxt     = '0;
    for (int d = 0; d < DEVICES; d++) begin
      if (cmd_r.device == 2'(d)) begin
        frame_nxt[d*SLOT_W +: SLOT_W] = {upd.reg_byte, upd.data_byte};
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    frame_r <= frame_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame      = frame_r;
  assign out_last_frame = last_r;

endmodule
